// File: rtl/core/sip_pkg.sv
// ============================================================================
// String-to-integer parser package
// Shared types, character codes, radix codes and digit decoding for the
// streaming string-to-integer parser.
// ============================================================================
`default_nettype none

package sip_pkg;

    // Default widths of the result value and the character counter.
    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    // Width of a radix and of a decoded digit.
    localparam int BASE_BITS = 6;

    // Character codes that steer the parse.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // Radix codes.
    localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_BIN  = 6'd2;
    localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;

    // Parse phase, one-hot.
    typedef enum logic [3:0] {
        PH_SPACE  = 4'b0001,
        PH_SIGNED = 4'b0010,
        PH_ZERO   = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    // Digit status of the number in progress.
    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_SEEN = 2'd1,
        ST_OVER = 2'd2
    } status_t;

    // Decoded digit: valid flag and its value 0..35.
    typedef struct packed {
        logic                 ok;
        logic [BASE_BITS-1:0] val;
    } digit_t;

    // Map a character to its digit value in either letter case.
    function automatic digit_t digit_of(input logic [7:0] c);
        digit_t d;
        logic [7:0] diff;
        d    = '0;
        diff = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            diff = c - CH_ZERO;
            d.ok = 1'b1;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            diff = c - CH_LO_A + 8'd10;
            d.ok = 1'b1;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            diff = c - CH_UP_A + 8'd10;
            d.ok = 1'b1;
        end
        d.val = diff[BASE_BITS-1:0];
        return d;
    endfunction

    // Whitespace: space, tab, line feed, vertical tab, form feed, carriage return.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/string_to_integer_parser.sv
// ============================================================================
// String-to-integer parser
// Parses a signed integer from a byte stream, one character per beat, with
// whitespace skipping, sign, radix prefixes and saturation on overflow.
// ============================================================================
//
//  Channel   Direction  Handshake               Payload
//  input     in         in_valid / in_ready     char_code
//  result    out        out_valid / out_ready   value, consumed, overflow, no_digits
//  config    in         cfg_wr_en               cfg_wr_data (number_base)
//
//  One character is accepted per cycle when the result side keeps up.
//  A character is captured in the input register; the parse step then updates the
//  state and loads the result register, so a result shows once its terminating
//  character has passed both registers, unless a stalled result holds the step.
//  The cycle is set by the parse step: one VALUE_BITS x 6 multiply-add and a
//  compare against the signed limit.
//  A stalled result holds the parse step, and the input register then fills.
//  Reset clears the parse state, the radix register and both valid flags.
//
`default_nettype none

module string_to_integer_parser
    import sip_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write
    input  wire logic                  cfg_wr_en,
    input  wire logic [BASE_BITS-1:0]  cfg_wr_data,
    // Character input
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            char_code,
    // Result output
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [VALUE_BITS-1:0] value,
    output logic [COUNT_BITS-1:0]      consumed,
    output logic                       overflow,
    output logic                       no_digits
);

    localparam int PROD_W = VALUE_BITS + BASE_BITS + 1;
    localparam logic [VALUE_BITS-1:0] HALF_VAL = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] MAX_POS  = ~HALF_VAL;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Radix register.
    logic [BASE_BITS-1:0] number_base_reg;

    // Input register.
    logic       stage_valid_reg;
    logic [7:0] char_reg;

    // Parse state.
    phase_t                phase_reg,    phase_next;
    logic                  negative_reg, negative_next;
    logic [BASE_BITS-1:0]  base_reg,     base_next;
    logic [VALUE_BITS-1:0] acc_reg,      acc_next;
    status_t               status_reg,   status_next;
    logic [COUNT_BITS-1:0] count_reg,    count_next;

    // Result register.
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [COUNT_BITS-1:0] consumed_reg;
    logic                  overflow_reg;
    logic                  no_digits_reg;

    // Parse step signals.
    logic                  advance;
    logic                  emit;
    logic                  do_first;
    logic [BASE_BITS-1:0]  first_base;
    logic                  do_take;
    logic [BASE_BITS-1:0]  take_base;
    status_t               take_status;
    digit_t                dig;
    logic                  dig_valid;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     limit;
    logic                  over;
    logic [COUNT_BITS-1:0] count_inc;
    logic [VALUE_BITS-1:0] emit_value;

    // Handshake: the parse step runs when the result register has room.
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    // Radix register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_AUTO;
        end
        else if (cfg_wr_en)
        begin
            number_base_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
        end
    end

    // Digit decode, multiply-add and overflow check.
    assign dig       = digit_of(char_reg);
    assign dig_valid = dig.ok && (dig.val < take_base);
    assign prod      = PROD_W'(acc_reg) * PROD_W'(take_base) + PROD_W'(dig.val);
    assign limit     = negative_reg ? PROD_W'(HALF_VAL) : PROD_W'(MAX_POS);
    assign over      = (take_status == ST_OVER) || (prod > limit);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_BITS'(1);

    // Parse step next state.
    always_comb
    begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        emit          = 1'b0;
        do_first      = 1'b0;
        first_base    = base_reg;
        do_take       = 1'b0;
        take_base     = base_reg;
        take_status   = status_reg;

        unique case (phase_reg)
            PH_SPACE:
            begin
                if (is_space(char_reg))
                begin
                    count_next = count_inc;
                end
                else if (char_reg == CH_MINUS || char_reg == CH_PLUS)
                begin
                    negative_next = (char_reg == CH_MINUS);
                    base_next     = number_base_reg;
                    phase_next    = PH_SIGNED;
                    count_next    = count_inc;
                end
                else
                begin
                    do_first   = 1'b1;
                    first_base = number_base_reg;
                end
            end
            PH_SIGNED:
            begin
                do_first = 1'b1;
            end
            PH_ZERO:
            begin
                if ((char_reg == CH_LO_X || char_reg == CH_UP_X) &&
                    (base_reg == BASE_AUTO || base_reg == BASE_HEX))
                begin
                    base_next  = BASE_HEX;
                    phase_next = PH_DIGITS;
                    count_next = count_inc;
                end
                else if ((char_reg == CH_LO_B || char_reg == CH_UP_B) &&
                         (base_reg == BASE_AUTO || base_reg == BASE_BIN))
                begin
                    base_next  = BASE_BIN;
                    phase_next = PH_DIGITS;
                    count_next = count_inc;
                end
                else
                begin
                    // The leading zero counts as a digit of value zero.
                    do_take     = 1'b1;
                    take_base   = (base_reg == BASE_AUTO) ? BASE_OCT : base_reg;
                    take_status = ST_SEEN;
                end
            end
            PH_DIGITS:
            begin
                do_take = 1'b1;
            end
            default:
            begin
                phase_next = PH_SPACE;
            end
        endcase

        // First character after whitespace and sign.
        if (do_first)
        begin
            if (char_reg == CH_ZERO && (first_base == BASE_AUTO ||
                first_base == BASE_HEX || first_base == BASE_BIN))
            begin
                base_next  = first_base;
                phase_next = PH_ZERO;
                count_next = count_inc;
            end
            else
            begin
                do_take   = 1'b1;
                take_base = (first_base == BASE_AUTO) ? BASE_DEC : first_base;
            end
        end

        // Digit or terminator.
        if (do_take)
        begin
            if (dig_valid)
            begin
                phase_next = PH_DIGITS;
                base_next  = take_base;
                count_next = count_inc;
                if (over)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    acc_next    = prod[VALUE_BITS-1:0];
                    status_next = ST_SEEN;
                end
            end
            else
            begin
                emit          = 1'b1;
                phase_next    = PH_SPACE;
                negative_next = 1'b0;
                base_next     = BASE_AUTO;
                acc_next      = '0;
                status_next   = ST_NONE;
                count_next    = '0;
            end
        end
    end

    // Result value, saturated on overflow.
    always_comb
    begin
        if (take_status == ST_OVER)
        begin
            emit_value = negative_reg ? HALF_VAL : MAX_POS;
        end
        else if (negative_reg)
        begin
            emit_value = (~acc_reg) + VALUE_BITS'(1);
        end
        else
        begin
            emit_value = acc_reg;
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SPACE;
            negative_reg <= 1'b0;
            base_reg     <= BASE_AUTO;
            acc_reg      <= '0;
            status_reg   <= ST_NONE;
            count_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            base_reg     <= base_next;
            acc_reg      <= acc_next;
            status_reg   <= status_next;
            count_reg    <= count_next;
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            value_reg     <= emit_value;
            consumed_reg  <= (take_status == ST_NONE) ? '0 : count_reg;
            overflow_reg  <= (take_status == ST_OVER);
            no_digits_reg <= (take_status == ST_NONE);
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign consumed  = consumed_reg;
    assign overflow  = overflow_reg;
    assign no_digits = no_digits_reg;

    // A result never carries both flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(overflow_reg && no_digits_reg))
    else $error("overflow and no_digits both set");

    // A number without digits reports zero value and zero length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && no_digits_reg) |-> (value_reg == '0 && consumed_reg == '0))
    else $error("no_digits result with nonzero value or length");

    // An overflowed result is saturated to one of the two limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && overflow_reg) |-> (value_reg == HALF_VAL || value_reg == MAX_POS))
    else $error("overflow result not saturated");

    // After a leading zero nothing has been accumulated yet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ZERO) |-> (acc_reg == '0 && status_reg == ST_NONE))
    else $error("accumulator busy during zero prefix");

    // The digit phase always runs with a nonzero radix.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DIGITS) |-> (base_reg != BASE_AUTO))
    else $error("digit phase with automatic radix");

    // A result waiting for the sink holds the parse step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
    else $error("parse step ran while result stalled");

endmodule

`default_nettype wire
